// ----- src/jsu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Result kinds, error codes, scanner phases, the batch of results that one
// input byte produces, and the hex-digit and UTF-8 helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned MaxResults = 4;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_OPEN     = 4'd1,
    ERR_UNTERM      = 4'd2,
    ERR_END_AFTER_BS = 4'd3,
    ERR_CTRL_CHAR   = 4'd4,
    ERR_BAD_ESCAPE  = 4'd5,
    ERR_SHORT_UNI   = 4'd6,
    ERR_BAD_HEX     = 4'd7,
    ERR_UNPAIRED_HI = 4'd8,
    ERR_BAD_LOW     = 4'd9,
    ERR_UNPAIRED_LO = 4'd10
  } err_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_BODY    = 4'd1,
    PH_ESC     = 4'd2,
    PH_HEX1    = 4'd3,
    PH_NEED_BS = 4'd4,
    PH_NEED_U  = 4'd5,
    PH_HEX2    = 4'd6
  } phase_t;

  // Surrogate ranges and UTF-8 limits
  localparam logic [15:0] HiSurrFirst = 16'hD800;
  localparam logic [15:0] HiSurrLast  = 16'hDBFF;
  localparam logic [15:0] LoSurrFirst = 16'hDC00;
  localparam logic [15:0] LoSurrLast  = 16'hDFFF;
  localparam logic [20:0] SuppBase    = 21'h10000;
  localparam logic [20:0] Utf8Max1    = 21'h7F;
  localparam logic [20:0] Utf8Max2    = 21'h7FF;
  localparam logic [20:0] Utf8Max3    = 21'hFFFF;
  localparam logic [7:0]  CtrlLimit   = 8'h20;

  // Scanner state
  typedef struct packed {
    phase_t      phase;
    logic [15:0] acc;
    logic [1:0]  cnt;
    logic [9:0]  high;
  } state_t;

  // Results caused by one input byte; bytes[0] goes out first
  typedef struct packed {
    logic [2:0]      num;
    kind_t           kind;
    err_t            err;
    logic [3:0][7:0] bytes;
  } batch_t;

  typedef struct packed {
    batch_t batch;
    state_t nxt;
  } dec_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [2:0]      num;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic hex_t hexdig(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= "0" && c <= "9") begin
      h.val = 4'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      h.val = 4'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      h.val = 4'(c - "A" + 8'd10);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp <= Utf8Max1) begin
      u.num      = 3'd1;
      u.bytes[0] = cp[7:0];
    end else if (cp <= Utf8Max2) begin
      u.num      = 3'd2;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= Utf8Max3) begin
      u.num      = 3'd3;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.num      = 3'd4;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// ----- src/jsu_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if: raw byte channel
// Valid/ready channel carrying one input byte and its end-of-input flag.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

// ----- src/jsu_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if: result channel
// Valid/ready channel carrying one decoded byte, close or error item.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input error_code,
                  input last, output ready);
endinterface

// ----- src/jsu_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode: one-byte step of the string scanner
// Combinational next-state logic and the batch of results for one byte.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  jsu_pkg::state_t st,
  input  logic [7:0]      ch,
  input  logic            eoi,
  output jsu_pkg::dec_t   dec
);

  jsu_pkg::hex_t   hx;
  logic [15:0]     acc_new;
  logic [20:0]     cp;
  jsu_pkg::utf8_t  enc;
  jsu_pkg::err_t   err;
  jsu_pkg::state_t nxt;
  jsu_pkg::batch_t bat;

  // Shift in the hex digit and build the code point for either \u form
  always_comb begin
    hx      = jsu_pkg::hexdig(ch);
    acc_new = {st.acc[11:0], hx.val};
    if (st.phase == jsu_pkg::PH_HEX2) begin
      cp = jsu_pkg::SuppBase + {1'b0, st.high, acc_new[9:0]};
    end else begin
      cp = {5'd0, acc_new};
    end
    enc = jsu_pkg::utf8_encode(cp);
  end

  // Scanner step
  always_comb begin
    nxt       = st;
    err       = jsu_pkg::ERR_NONE;
    bat.num   = 3'd0;
    bat.kind  = jsu_pkg::KIND_BYTE;
    bat.err   = jsu_pkg::ERR_NONE;
    bat.bytes = '0;
    unique case (st.phase)
      jsu_pkg::PH_BODY: begin
        if (ch == "\"") begin
          bat.num   = 3'd1;
          bat.kind  = jsu_pkg::KIND_CLOSE;
          nxt.phase = jsu_pkg::PH_IDLE;
        end else if (ch < jsu_pkg::CtrlLimit) begin
          err = jsu_pkg::ERR_CTRL_CHAR;
        end else if (ch == "\\") begin
          if (eoi) err = jsu_pkg::ERR_END_AFTER_BS;
          else nxt.phase = jsu_pkg::PH_ESC;
        end else if (eoi) begin
          err = jsu_pkg::ERR_UNTERM;
        end else begin
          bat.num      = 3'd1;
          bat.bytes[0] = ch;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (ch == "u") begin
          if (eoi) begin
            err = jsu_pkg::ERR_SHORT_UNI;
          end else begin
            nxt.phase = jsu_pkg::PH_HEX1;
            nxt.acc   = '0;
            nxt.cnt   = '0;
          end
        end else begin
          // Map the short escapes
          bat.bytes[0] = 8'h00;
          unique case (ch)
            "\"":    bat.bytes[0] = 8'h22;
            "\\":    bat.bytes[0] = 8'h5C;
            "/":     bat.bytes[0] = 8'h2F;
            "b":     bat.bytes[0] = 8'h08;
            "f":     bat.bytes[0] = 8'h0C;
            "n":     bat.bytes[0] = 8'h0A;
            "r":     bat.bytes[0] = 8'h0D;
            "t":     bat.bytes[0] = 8'h09;
            default: err = jsu_pkg::ERR_BAD_ESCAPE;
          endcase
          if (err == jsu_pkg::ERR_NONE) begin
            if (eoi) begin
              err = jsu_pkg::ERR_UNTERM;
            end else begin
              bat.num   = 3'd1;
              nxt.phase = jsu_pkg::PH_BODY;
            end
          end
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (!hx.ok) begin
          err = jsu_pkg::ERR_BAD_HEX;
        end else begin
          nxt.acc = acc_new;
          if (st.cnt != 2'd3) begin
            nxt.cnt = st.cnt + 2'd1;
            if (eoi) begin
              err = (st.phase == jsu_pkg::PH_HEX1) ? jsu_pkg::ERR_SHORT_UNI
                                                   : jsu_pkg::ERR_UNPAIRED_HI;
            end
          end else begin
            nxt.cnt = 2'd0;
            if (st.phase == jsu_pkg::PH_HEX1) begin
              if (acc_new >= jsu_pkg::HiSurrFirst && acc_new <= jsu_pkg::HiSurrLast) begin
                if (eoi) begin
                  err = jsu_pkg::ERR_UNPAIRED_HI;
                end else begin
                  nxt.high  = acc_new[9:0];
                  nxt.phase = jsu_pkg::PH_NEED_BS;
                end
              end else if (acc_new >= jsu_pkg::LoSurrFirst &&
                           acc_new <= jsu_pkg::LoSurrLast) begin
                err = jsu_pkg::ERR_UNPAIRED_LO;
              end else if (eoi) begin
                err = jsu_pkg::ERR_UNTERM;
              end else begin
                bat.num   = enc.num;
                bat.bytes = enc.bytes;
                nxt.phase = jsu_pkg::PH_BODY;
              end
            end else begin
              if (acc_new < jsu_pkg::LoSurrFirst || acc_new > jsu_pkg::LoSurrLast) begin
                err = jsu_pkg::ERR_BAD_LOW;
              end else if (eoi) begin
                err = jsu_pkg::ERR_UNTERM;
              end else begin
                bat.num   = enc.num;
                bat.bytes = enc.bytes;
                nxt.phase = jsu_pkg::PH_BODY;
              end
            end
          end
        end
      end
      jsu_pkg::PH_NEED_BS: begin
        if (ch != "\\" || eoi) err = jsu_pkg::ERR_UNPAIRED_HI;
        else nxt.phase = jsu_pkg::PH_NEED_U;
      end
      jsu_pkg::PH_NEED_U: begin
        if (ch != "u" || eoi) begin
          err = jsu_pkg::ERR_UNPAIRED_HI;
        end else begin
          nxt.phase = jsu_pkg::PH_HEX2;
          nxt.acc   = '0;
          nxt.cnt   = '0;
        end
      end
      default: begin
        // Idle: wait for the opening quote
        if (ch != "\"") err = jsu_pkg::ERR_NO_OPEN;
        else if (eoi) err = jsu_pkg::ERR_UNTERM;
        else nxt.phase = jsu_pkg::PH_BODY;
      end
    endcase

    // Any error replaces the batch and drops back to idle
    if (err != jsu_pkg::ERR_NONE) begin
      bat.num   = 3'd1;
      bat.kind  = jsu_pkg::KIND_ERROR;
      bat.err   = err;
      bat.bytes = '0;
      nxt.phase = jsu_pkg::PH_IDLE;
      nxt.acc   = '0;
      nxt.cnt   = '0;
      nxt.high  = '0;
    end

    dec.batch = bat;
    dec.nxt   = nxt;
  end

endmodule

// ----- src/jsu_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_emit: result register and serialiser
// Holds the batch of one input byte and sends it out one item per cycle while tx is ready.
// ----------------------------------------------------------------------------
module jsu_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  jsu_pkg::batch_t   batch,
  output logic              free,
  jsu_out_if.source         tx
);

  logic            busy;
  logic [1:0]      idx;
  logic [1:0]      cnt_m1;
  jsu_pkg::kind_t  kind;
  jsu_pkg::err_t   err;
  logic [3:0][7:0] bytes;
  logic            at_last;
  logic            take;

  assign at_last = (idx == cnt_m1);
  assign take    = busy && tx.ready;
  assign free    = !busy || (take && at_last);

  // Control: load a new batch or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      if (at_last) busy <= 1'b0;
      else idx <= idx + 2'd1;
    end
  end

  // Payload: hold the batch contents
  always_ff @(posedge clk) begin
    if (load) begin
      cnt_m1 <= 2'(batch.num - 3'd1);
      kind   <= batch.kind;
      err    <= batch.err;
      bytes  <= batch.bytes;
    end
  end

  // Drive the result channel
  assign tx.valid      = busy;
  assign tx.kind       = kind;
  assign tx.out_byte   = (kind == jsu_pkg::KIND_BYTE) ? bytes[idx] : 8'h00;
  assign tx.error_code = err;
  assign tx.last       = at_last;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= cnt_m1)
    else $error("serialiser index past end of batch");

  a_single_non_byte: assert property (@(posedge clk) disable iff (rst)
    busy && kind != jsu_pkg::KIND_BYTE |-> cnt_m1 == 2'd0)
    else $error("close or error batch holds more than one item");

  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && idx == 2'd0)
    else $error("loaded batch not presented from its first item");

endmodule

// ----- src/json_string_unescape_utf8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string literal unescaper with UTF-8 output
// Input register, one-byte scanner step, and a result serialiser.
// ----------------------------------------------------------------------------
// Feed a JSON string literal on rx one byte per item, starting with the
// opening quote. Each byte yields zero to four items on tx: decoded bytes,
// a close item at the closing quote, or one error item, after which the
// block waits for the next opening quote. A byte is decoded from the input
// register; its batch is held in the serialiser's result register. The
// sustained rate is one input byte per cycle while each byte yields at most
// one item and tx is ready; a byte yielding several items holds the input
// until its last item is taken, as the result channel carries one item per
// cycle. There is no clearing pass after reset.
module json_string_unescape_utf8 (
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    rx,
  jsu_out_if.source tx
);

  logic            in_q_valid;
  logic [7:0]      ch_q;
  logic            eoi_q;
  jsu_pkg::state_t state;
  jsu_pkg::dec_t   dec;
  logic            free;
  logic            advance;
  logic            load;

  // Hand the decoded byte on when its batch fits, or when it yields nothing
  assign advance  = in_q_valid && (dec.batch.num == 3'd0 || free);
  assign load     = advance && dec.batch.num != 3'd0;
  assign rx.ready = !in_q_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (rx.ready) begin
      in_q_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      ch_q  <= rx.ch;
      eoi_q <= rx.end_of_input;
    end
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase <= jsu_pkg::PH_IDLE;
      state.acc   <= '0;
      state.cnt   <= '0;
      state.high  <= '0;
    end else if (advance) begin
      state <= dec.nxt;
    end
  end

  jsu_decode u_decode (
    .st  (state),
    .ch  (ch_q),
    .eoi (eoi_q),
    .dec (dec)
  );

  jsu_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .batch (dec.batch),
    .free  (free),
    .tx    (tx)
  );

  a_error_to_idle: assert property (@(posedge clk) disable iff (rst)
    advance && dec.batch.kind == jsu_pkg::KIND_ERROR
      |=> state.phase == jsu_pkg::PH_IDLE && state.high == 10'd0)
    else $error("scanner not idle after an error item");

  a_accept_registers: assert property (@(posedge clk) disable iff (rst)
    rx.valid && rx.ready |=> in_q_valid)
    else $error("accepted byte lost from input register");

endmodule

// ----- test/json_string_unescape_utf8_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test: self-checking bench for the JSON unescaper
// Feeds string literals byte by byte: a directed opening, then random
// literals (mostly well formed, some truncated, corrupted or preceded by
// noise). A scanner model predicts every result item; the result channel is
// checked item by item. Both channels idle at random, and the receiver holds
// off once for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBytes = 400;
  localparam int unsigned LongHold    = 250;
  localparam int unsigned HoldAfter   = 120;

  localparam logic [7:0] QuoteCh     = 8'h22;
  localparam logic [7:0] BackslashCh = 8'h5C;
  localparam logic [7:0] SlashCh     = 8'h2F;
  localparam logic [7:0] LetterU     = 8'h75;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } raw_byte_t;

  typedef struct packed {
    jsu_pkg::kind_t kind;
    logic [7:0]     val;
    jsu_pkg::err_t  code;
    logic           last;
  } result_t;

  logic clk;
  logic rst;

  jsu_in_if  rx_if ();
  jsu_out_if tx_if ();

  json_string_unescape_utf8 dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  raw_byte_t   pending_bytes[$];
  result_t     expected_results[$];
  logic [7:0]  lit_q[$];

  // Scanner model state
  jsu_pkg::phase_t scan_phase;
  logic [15:0]     hex_acc;
  logic [1:0]      hex_cnt;
  logic [9:0]      high_part;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned bytes_in;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_left;
  int unsigned hold_seen;
  bit          hold_done;
  bit          byte_taken;

  always #4 clk = ~clk;

  // Append one expected item to the scoreboard
  task automatic append_result(input result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Append one byte to the literal under construction
  task automatic append_lit(input logic [7:0] c);
    lit_q.insert(lit_q.size(), c);
  endtask

  // Advance the scanner model by one input byte and queue the items it yields
  task automatic unescape_step(input logic [7:0] c, input logic eoi);
    jsu_pkg::err_t fault;
    logic [7:0]    bytes_q[$];
    logic          closed;
    logic          emit_cp;
    logic          esc_ok;
    logic          nib_ok;
    logic [3:0]    nib;
    logic [7:0]    esc;
    logic [20:0]   cp;
    fault   = jsu_pkg::ERR_NONE;
    closed  = 1'b0;
    emit_cp = 1'b0;
    esc_ok  = 1'b1;
    nib_ok  = 1'b1;
    nib     = 4'd0;
    esc     = 8'd0;
    cp      = 21'd0;
    case (scan_phase)
      jsu_pkg::PH_BODY: begin
        if (c == QuoteCh) begin
          closed     = 1'b1;
          scan_phase = jsu_pkg::PH_IDLE;
        end else if (c < 8'h20) begin
          fault = jsu_pkg::ERR_CTRL_CHAR;
        end else if (c == BackslashCh) begin
          if (eoi) fault = jsu_pkg::ERR_END_AFTER_BS;
          else scan_phase = jsu_pkg::PH_ESC;
        end else if (eoi) begin
          fault = jsu_pkg::ERR_UNTERM;
        end else begin
          bytes_q.insert(bytes_q.size(), c);
        end
      end
      jsu_pkg::PH_ESC: begin
        if (c == LetterU) begin
          if (eoi) begin
            fault = jsu_pkg::ERR_SHORT_UNI;
          end else begin
            scan_phase = jsu_pkg::PH_HEX1;
            hex_acc    = 16'd0;
            hex_cnt    = 2'd0;
          end
        end else begin
          case (c)
            QuoteCh, BackslashCh, SlashCh: esc = c;
            "b": esc = 8'h08;
            "f": esc = 8'h0C;
            "n": esc = 8'h0A;
            "r": esc = 8'h0D;
            "t": esc = 8'h09;
            default: esc_ok = 1'b0;
          endcase
          if (!esc_ok) begin
            fault = jsu_pkg::ERR_BAD_ESCAPE;
          end else if (eoi) begin
            fault = jsu_pkg::ERR_UNTERM;
          end else begin
            bytes_q.insert(bytes_q.size(), esc);
            scan_phase = jsu_pkg::PH_BODY;
          end
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
        if (c >= "0" && c <= "9") nib = 4'(c - 8'h30);
        else if (c >= "a" && c <= "f") nib = 4'(c - 8'h57);
        else if (c >= "A" && c <= "F") nib = 4'(c - 8'h37);
        else nib_ok = 1'b0;
        if (!nib_ok) begin
          fault = jsu_pkg::ERR_BAD_HEX;
        end else begin
          hex_acc = {hex_acc[11:0], nib};
          if (hex_cnt < 2'd3) begin
            hex_cnt++;
            if (eoi) begin
              if (scan_phase == jsu_pkg::PH_HEX1) fault = jsu_pkg::ERR_SHORT_UNI;
              else fault = jsu_pkg::ERR_UNPAIRED_HI;
            end
          end else begin
            hex_cnt = 2'd0;
            if (scan_phase == jsu_pkg::PH_HEX1) begin
              if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                if (eoi) begin
                  fault = jsu_pkg::ERR_UNPAIRED_HI;
                end else begin
                  high_part  = hex_acc[9:0];
                  scan_phase = jsu_pkg::PH_NEED_BS;
                end
              end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                fault = jsu_pkg::ERR_UNPAIRED_LO;
              end else if (eoi) begin
                fault = jsu_pkg::ERR_UNTERM;
              end else begin
                cp         = {5'd0, hex_acc};
                emit_cp    = 1'b1;
                scan_phase = jsu_pkg::PH_BODY;
              end
            end else begin
              if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                fault = jsu_pkg::ERR_BAD_LOW;
              end else if (eoi) begin
                fault = jsu_pkg::ERR_UNTERM;
              end else begin
                cp         = 21'h10000 + {1'b0, high_part, hex_acc[9:0]};
                emit_cp    = 1'b1;
                scan_phase = jsu_pkg::PH_BODY;
              end
            end
          end
        end
      end
      jsu_pkg::PH_NEED_BS: begin
        if (c != BackslashCh || eoi) fault = jsu_pkg::ERR_UNPAIRED_HI;
        else scan_phase = jsu_pkg::PH_NEED_U;
      end
      jsu_pkg::PH_NEED_U: begin
        if (c != LetterU || eoi) begin
          fault = jsu_pkg::ERR_UNPAIRED_HI;
        end else begin
          scan_phase = jsu_pkg::PH_HEX2;
          hex_acc    = 16'd0;
          hex_cnt    = 2'd0;
        end
      end
      default: begin
        if (c != QuoteCh) fault = jsu_pkg::ERR_NO_OPEN;
        else if (eoi) fault = jsu_pkg::ERR_UNTERM;
        else scan_phase = jsu_pkg::PH_BODY;
      end
    endcase

    // Encode the finished code point as a UTF-8 run
    if (emit_cp) begin
      if (cp < 21'h80) begin
        bytes_q.insert(bytes_q.size(), cp[7:0]);
      end else if (cp < 21'h800) begin
        bytes_q.insert(bytes_q.size(), 8'hC0 | 8'(cp[10:6]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[5:0]));
      end else if (cp < 21'h10000) begin
        bytes_q.insert(bytes_q.size(), 8'hE0 | 8'(cp[15:12]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[11:6]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[5:0]));
      end else begin
        bytes_q.insert(bytes_q.size(), 8'hF0 | 8'(cp[20:18]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[17:12]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[11:6]));
        bytes_q.insert(bytes_q.size(), 8'h80 | 8'(cp[5:0]));
      end
    end

    // An error drops any decoded bytes and clears the scanner
    if (fault != jsu_pkg::ERR_NONE) begin
      append_result('{jsu_pkg::KIND_ERROR, 8'h00, fault, 1'b1});
      scan_phase = jsu_pkg::PH_IDLE;
      hex_acc    = 16'd0;
      hex_cnt    = 2'd0;
      high_part  = 10'd0;
    end else if (closed) begin
      append_result('{jsu_pkg::KIND_CLOSE, 8'h00, jsu_pkg::ERR_NONE, 1'b1});
    end else begin
      foreach (bytes_q[i])
        append_result('{jsu_pkg::KIND_BYTE, bytes_q[i], jsu_pkg::ERR_NONE,
                        1'(i == bytes_q.size() - 1)});
    end
  endtask

  task automatic queue_byte(input logic [7:0] c, input logic eoi);
    pending_bytes.insert(pending_bytes.size(), '{c, eoi});
  endtask

  task automatic queue_text(input string s, input bit eoi_last);
    for (int i = 0; i < s.len(); i++)
      queue_byte(s[i], eoi_last && (i == s.len() - 1));
  endtask

  // Append a \u escape with hex digits in random case
  task automatic add_u(input logic [15:0] v);
    logic [3:0] nib;
    append_lit(BackslashCh);
    append_lit(LetterU);
    for (int i = 3; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib < 4'd10) append_lit(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1) == 0) append_lit(8'h57 + 8'(nib));
      else append_lit(8'h37 + 8'(nib));
    end
  endtask

  // Append one random token of string content
  task automatic add_token();
    logic [7:0]  c;
    logic [15:0] v;
    logic [15:0] hi;
    logic [15:0] lo;
    c  = 8'd0;
    v  = 16'd0;
    hi = 16'($urandom_range(16'hD800, 16'hDBFF));
    lo = 16'($urandom_range(16'hDC00, 16'hDFFF));
    if ($urandom_range(0, 5) == 0) hi = $urandom_range(0, 1) ? 16'hD800 : 16'hDBFF;
    if ($urandom_range(0, 5) == 0) lo = $urandom_range(0, 1) ? 16'hDC00 : 16'hDFFF;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        c = 8'($urandom_range(8'h20, 8'h7E));
        if (c == QuoteCh || c == BackslashCh) append_lit(BackslashCh);
        append_lit(c);
      end
      3: append_lit(8'($urandom_range(8'h80, 8'hFF)));
      4, 5: begin
        case ($urandom_range(0, 7))
          0: c = QuoteCh;
          1: c = BackslashCh;
          2: c = SlashCh;
          3: c = "b";
          4: c = "f";
          5: c = "n";
          6: c = "r";
          default: c = "t";
        endcase
        append_lit(BackslashCh);
        append_lit(c);
      end
      6: begin
        case ($urandom_range(0, 3))
          0: v = 16'($urandom_range(0, 16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: begin
            v = 16'($urandom_range(16'h800, 16'hF7FF));
            if (v >= 16'hD800) v = v + 16'h800;
          end
          default: begin
            // UTF-8 length boundaries
            case ($urandom_range(0, 5))
              0: v = 16'h0000;
              1: v = 16'h007F;
              2: v = 16'h0080;
              3: v = 16'h07FF;
              4: v = 16'h0800;
              default: v = 16'hFFFF;
            endcase
          end
        endcase
        add_u(v);
      end
      7, 8: begin
        add_u(hi);
        add_u(lo);
      end
      default: begin
        // broken surrogate sequences
        case ($urandom_range(0, 3))
          0: add_u(lo);
          1: begin
            add_u(hi);
            append_lit("x");
          end
          2: begin
            add_u(hi);
            append_lit(BackslashCh);
            append_lit("n");
          end
          default: begin
            add_u(hi);
            add_u(16'($urandom_range(0, 16'hDBFF)));
          end
        endcase
      end
    endcase
  endtask

  function automatic bit idling_on();
    return pending_bytes.size() > 48 && ((bytes_in / 40) % 4 != 3);
  endfunction

  // Accept input items into the model and check result items
  always @(posedge clk) begin
    result_t want;
    cycle_count++;
    byte_taken = 1'b0;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        unescape_step(rx_if.ch, rx_if.end_of_input);
        void'(pending_bytes.pop_front());
        byte_taken = 1'b1;
        bytes_in++;
      end
      if (tx_if.valid && tx_if.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected item: kind=%0d byte=%02h code=%0d last=%0b",
                   $time, tx_if.kind, tx_if.out_byte, tx_if.error_code, tx_if.last);
        end else begin
          want = expected_results.pop_front();
          if (tx_if.kind !== want.kind || tx_if.out_byte !== want.val ||
              tx_if.error_code !== want.code || tx_if.last !== want.last) begin
            error_count++;
            $display("%0t: mismatch: expected kind=%0d byte=%02h code=%0d last=%0b, got kind=%0d byte=%02h code=%0d last=%0b",
                     $time, want.kind, want.val, want.code, want.last,
                     tx_if.kind, tx_if.out_byte, tx_if.error_code, tx_if.last);
          end
        end
      end
    end
  end

  // Long receiver hold-off, counted here once enough input has gone in
  always @(posedge clk) begin
    if (!rst && rx_if.valid && rx_if.ready) hold_seen++;
    if (hold_left > 0) begin
      hold_left--;
    end else if (!hold_done && hold_seen >= HoldAfter) begin
      hold_left = LongHold;
      hold_done = 1'b1;
    end
  end

  // Offer pending bytes; hold the current one until it is taken
  always @(negedge clk) begin
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (idling_on() && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 10);
        rx_if.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        rx_if.valid        <= 1'b1;
        rx_if.ch           <= pending_bytes[0].ch;
        rx_if.end_of_input <= pending_bytes[0].eoi;
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel in random bursts
  always @(negedge clk) begin
    if (rst || hold_left > 0) begin
      tx_if.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      tx_if.ready <= 1'b0;
    end else if (idling_on() && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 10);
      tx_if.ready <= 1'b0;
    end else begin
      tx_if.ready <= 1'b1;
    end
  end

  initial begin
    int eoi_at;
    int cut;
    rst                = 1'b1;
    clk                = 1'b0;
    rx_if.valid        = 1'b0;
    rx_if.ch           = 8'h00;
    rx_if.end_of_input = 1'b0;
    tx_if.ready        = 1'b0;
    scan_phase         = jsu_pkg::PH_IDLE;
    hex_acc            = 16'd0;
    hex_cnt            = 2'd0;
    high_part          = 10'd0;
    cycle_count        = 0;
    error_count        = 0;
    bytes_in           = 0;
    send_gap           = 0;
    recv_gap           = 0;
    hold_left          = 0;
    hold_seen          = 0;
    hold_done          = 1'b0;
    byte_taken         = 1'b0;

    // Directed: missing opening quote, quote at end of input, non-ASCII
    // pass-through with a surrogate pair closed on the last byte, end after
    // backslash, control character, bad hex digit
    queue_byte(8'h00, 1'b0);
    queue_text("\"", 1'b1);
    queue_text("\"", 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_text("\\uD83D\\ude00", 1'b0);
    queue_text("\"", 1'b1);
    queue_text("\"\\", 1'b1);
    queue_text("\"", 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_text("\"\\ug", 1'b0);

    // Random literals: mostly well formed, some truncated, corrupted or noisy
    while (pending_bytes.size() < RandomBytes + 25) begin
      lit_q.delete();
      append_lit(QuoteCh);
      repeat ($urandom_range(0, 6)) add_token();
      append_lit(QuoteCh);
      eoi_at = -1;
      case ($urandom_range(0, 9))
        0: begin
          cut = $urandom_range(0, lit_q.size() - 1);
          while (lit_q.size() > cut + 1) void'(lit_q.pop_back());
          eoi_at = cut;
        end
        1: lit_q[$urandom_range(0, lit_q.size() - 1)] = 8'($urandom_range(0, 255));
        2: begin
          repeat ($urandom_range(1, 3))
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        default: if ($urandom_range(0, 3) == 0) eoi_at = lit_q.size() - 1;
      endcase
      foreach (lit_q[i]) queue_byte(lit_q[i], i == eoi_at);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the stimulus to drain and every result to arrive
    while ((pending_bytes.size() != 0 || expected_results.size() != 0) &&
           cycle_count < CycleLimit)
      @(negedge clk);
    if (cycle_count < CycleLimit) repeat (DrainCycles) @(negedge clk);

    if (expected_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d items never arrived, first expected kind=%0d byte=%02h code=%0d last=%0b",
               $time, expected_results.size(), expected_results[0].kind,
               expected_results[0].val, expected_results[0].code, expected_results[0].last);
    end

    if (cycle_count < CycleLimit && error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
